/* sv/fabsf_pkg.sv */
// ---------------------------------------------------------------------------
// fabsf_pkg
// Shared types and constants for the flag and address bit stuffing framer.
// ---------------------------------------------------------------------------
package fabsf_pkg;

   localparam logic [7:0] FLAG_PATTERN = 8'h7E;
   localparam int         RUN_WIDTH    = 3;
   localparam logic [RUN_WIDTH-1:0] STUFF_LIMIT = 3'd5;
   localparam int         ADDR_WIDTH   = 3;

   typedef struct packed {
      logic                  data_bit;
      logic [ADDR_WIDTH-1:0] dest_address;
      logic                  last_bit;
   } req_type;

   typedef struct packed {
      logic line_bit;
      logic run_end;
      logic frame_end;
   } rsp_type;

endpackage

/* sv/fabsf_if.sv */
// ---------------------------------------------------------------------------
// fabsf_if
// Valid/ready channels for framer payload bits and serial line bits.
// ---------------------------------------------------------------------------
interface fabsf_req_if;
   logic       valid;
   logic       ready;
   logic       data_bit;
   logic [2:0] dest_address;
   logic       last_bit;

   modport source (output valid, output data_bit, output dest_address, output last_bit,
                   input ready);
   modport sink (input valid, input data_bit, input dest_address, input last_bit,
                 output ready);
endinterface

interface fabsf_rsp_if;
   logic valid;
   logic ready;
   logic line_bit;
   logic run_end;
   logic frame_end;

   modport source (output valid, output line_bit, output run_end, output frame_end,
                   input ready);
   modport sink (input valid, input line_bit, input run_end, input frame_end,
                 output ready);
endinterface

/* sv/fabsf_seq.sv */
// ---------------------------------------------------------------------------
// fabsf_seq
// Holds one payload item and walks it through opening flag, address, data,
// stuffed zero and closing flag, one line bit per transfer.
// ---------------------------------------------------------------------------
module fabsf_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fabsf_pkg::req_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output fabsf_pkg::rsp_type out_item
);
   import fabsf_pkg::*;

   localparam logic [1:0] PH_OPEN  = 2'd0;
   localparam logic [1:0] PH_DATA  = 2'd1;
   localparam logic [1:0] PH_STUFF = 2'd2;
   localparam logic [1:0] PH_CLOSE = 2'd3;

   localparam logic [3:0] FLAG_LAST = 4'd7;
   localparam logic [3:0] ADDR_LAST = 4'd10;

   req_type              item_ff,     item_in;
   logic                 item_vld_ff, item_vld_in;
   logic [1:0]           phase_ff,    phase_in;
   logic [3:0]           cnt_ff,      cnt_in;
   logic                 in_frame_ff, in_frame_in;
   logic [RUN_WIDTH-1:0] ones_ff,     ones_in;

   logic [RUN_WIDTH-1:0] ones_next;
   logic                 stuff_due;
   logic                 final_bit;
   logic                 advance;
   logic                 done;
   logic                 load;
   logic                 frame_open;
   logic [3:0]           addr_pos;
   logic                 line_bit;

   always_comb begin
      ones_next = item_ff.data_bit ? ones_ff + 3'd1 : '0;
      stuff_due = (ones_next >= STUFF_LIMIT);
      addr_pos  = ADDR_LAST - cnt_ff;
      advance   = item_vld_ff && out_ready;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      ones_in   = ones_ff;
      final_bit = 1'b0;
      line_bit  = 1'b0;
      unique case (phase_ff)
         PH_OPEN: begin
            if (cnt_ff <= FLAG_LAST) begin
               line_bit = FLAG_PATTERN[3'd7 - cnt_ff[2:0]];
            end else begin
               line_bit = item_ff.dest_address[addr_pos[1:0]];
            end
            if (advance) begin
               ones_in = '0;
               if (cnt_ff == ADDR_LAST) begin
                  phase_in = PH_DATA;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         PH_DATA: begin
            line_bit  = item_ff.data_bit;
            final_bit = !stuff_due && !item_ff.last_bit;
            if (advance) begin
               if (stuff_due) begin
                  ones_in  = '0;
                  phase_in = PH_STUFF;
               end else begin
                  ones_in = ones_next;
                  if (item_ff.last_bit) begin
                     phase_in = PH_CLOSE;
                     cnt_in   = '0;
                  end
               end
            end
         end
         PH_STUFF: begin
            line_bit  = 1'b0;
            final_bit = !item_ff.last_bit;
            if (advance && item_ff.last_bit) begin
               phase_in = PH_CLOSE;
               cnt_in   = '0;
            end
         end
         PH_CLOSE: begin
            line_bit  = FLAG_PATTERN[3'd7 - cnt_ff[2:0]];
            final_bit = (cnt_ff == FLAG_LAST);
            if (advance) begin
               ones_in = '0;
               cnt_in  = cnt_ff + 4'd1;
            end
         end
         default: begin
            line_bit = 1'b0;
         end
      endcase

      done       = advance && final_bit;
      in_ready   = !item_vld_ff || done;
      load       = in_valid && in_ready;
      frame_open = (done && item_ff.last_bit) ? 1'b0 : in_frame_ff;

      item_in     = item_ff;
      item_vld_in = item_vld_ff;
      if (done) begin
         item_vld_in = 1'b0;
      end
      if (load) begin
         item_in     = in_item;
         item_vld_in = 1'b1;
         phase_in    = frame_open ? PH_DATA : PH_OPEN;
         cnt_in      = '0;
      end
      in_frame_in = load || frame_open;

      out_valid          = item_vld_ff;
      out_item.line_bit  = line_bit;
      out_item.run_end   = final_bit;
      out_item.frame_end = (phase_ff == PH_CLOSE) && final_bit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         phase_ff    <= PH_OPEN;
         cnt_ff      <= '0;
         in_frame_ff <= 1'b0;
         ones_ff     <= '0;
      end else begin
         item_vld_ff <= item_vld_in;
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         in_frame_ff <= in_frame_in;
         ones_ff     <= ones_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

/* sv/fabsf_out.sv */
// ---------------------------------------------------------------------------
// fabsf_out
// Output register stage between the sequencer and the line side.
// ---------------------------------------------------------------------------
module fabsf_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fabsf_pkg::rsp_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output fabsf_pkg::rsp_type out_item
);
   import fabsf_pkg::*;

   rsp_type data_ff, data_in;
   logic    vld_ff,  vld_in;

   always_comb begin
      in_ready = !vld_ff || out_ready;
      data_in  = data_ff;
      vld_in   = vld_ff && !out_ready;
      if (in_valid && in_ready) begin
         data_in = in_item;
         vld_in  = 1'b1;
      end
      out_valid = vld_ff;
      out_item  = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* sv/flag_address_bit_stuffing_framer.sv */
// ---------------------------------------------------------------------------
// flag_address_bit_stuffing_framer
// Serial frame builder: opening flag, 3-bit address, bit-stuffed payload and
// closing flag, one line bit per output transfer.
// ---------------------------------------------------------------------------
// Each payload bit in, one line bit out per cycle while the line side is ready.
// A payload item inside a frame gives its data bit, plus a stuffed zero
// after five payload ones; the first item of a frame also sends the
// opening flag and address, and the last also sends the closing flag. The
// single-bit serializer output paces the input: req_ready drops while flag,
// address or stuffed bits go out. An accepted item's first line bit passes
// through the item register and then the output register.
module flag_address_bit_stuffing_framer (
   input logic        clock,
   input logic        reset,
   fabsf_req_if.sink  req_ch,
   fabsf_rsp_if.source rsp_ch
);
   import fabsf_pkg::*;

   req_type req_item;
   rsp_type seq_item;
   rsp_type rsp_item;
   logic    seq_valid;
   logic    seq_ready;

   assign req_item.data_bit     = req_ch.data_bit;
   assign req_item.dest_address = req_ch.dest_address;
   assign req_item.last_bit     = req_ch.last_bit;

   fabsf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_item   (req_item),
      .out_valid (seq_valid),
      .out_ready (seq_ready),
      .out_item  (seq_item)
   );

   fabsf_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seq_valid),
      .in_ready  (seq_ready),
      .in_item   (seq_item),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (rsp_item)
   );

   assign rsp_ch.line_bit  = rsp_item.line_bit;
   assign rsp_ch.run_end   = rsp_item.run_end;
   assign rsp_ch.frame_end = rsp_item.frame_end;

endmodule

/* sv/fabsf_chk.sv */
// ---------------------------------------------------------------------------
// fabsf_chk
// Port-level checks on the framer's line output.
// ---------------------------------------------------------------------------
module fabsf_chk (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic line_bit,
   input logic run_end,
   input logic frame_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(line_bit)
         && $stable(run_end) && $stable(frame_end))
      else $error("line output changed while stalled");

   a_frame_end_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_end |-> run_end)
      else $error("frame end without run end");

   a_frame_end_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_end |-> !line_bit)
      else $error("closing flag does not end in zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("line output valid right after reset");

endmodule

bind flag_address_bit_stuffing_framer fabsf_chk u_fabsf_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .line_bit  (rsp_ch.line_bit),
   .run_end   (rsp_ch.run_end),
   .frame_end (rsp_ch.frame_end)
);
